/* src/timer_deadline_min_heap_defines.svh */
// Assertion macros for the timer heap.
`ifndef TIMER_DEADLINE_MIN_HEAP_DEFINES_SVH
`define TIMER_DEADLINE_MIN_HEAP_DEFINES_SVH

`ifndef ASSERT_OFF
`define TDMH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define TDMH_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define TDMH_ASSERT(lbl, clk, rst_n, prop)
`define TDMH_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* src/tdmh_pkg.sv */
`default_nettype none

package tdmh_pkg;

  localparam int TIME_BITS   = 48;
  localparam int TAG_BITS    = 16;
  localparam int STATUS_BITS = 3;
  localparam int OCC_BITS    = 6;
  localparam int ENTRY_BITS  = TIME_BITS + TAG_BITS;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POLL   = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_EXPIRED  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FIRED    = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_IDLE     = 3'd4;

  typedef struct packed {
    logic                 op;
    logic [TIME_BITS-1:0] now_time;
    logic [TIME_BITS-1:0] deadline;
    logic [TAG_BITS-1:0]  tag;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [TAG_BITS-1:0]    out_tag;
    logic [TIME_BITS-1:0]   out_deadline;
    logic [OCC_BITS-1:0]    occupancy;
  } out_word_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [TAG_BITS-1:0]  tag;
  } entry_t;

endpackage

`default_nettype wire

/* src/tdmh_ram.sv */
`default_nettype none

module tdmh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/timer_deadline_min_heap.sv */
// Channel   Ports                    Handshake
// input     start, busy, in_word     taken when start && !busy
// result    out_valid, out_word      one-cycle strobe, always taken
//
// Rejected inserts and empty polls: result the cycle after start, busy stays low.
// Insert: S_UP_RD reads each parent, S_UP_CMP compares; S_UP_RD writes at the root.
// Poll: S_POP_CHK checks the root, S_POP_LAST fetches the last timer, then each child level compared
// takes S_DN_L, S_DN_R, S_DN_RC if a right child, S_DN_CMP, then S_DN_L in a leaf; one RAM read port sets these.
// Reset clears the count and the sequencer; heap RAM contents are not cleared.
// The receiver cannot stall results, so no stall adds to these steps.
`default_nettype none
`include "timer_deadline_min_heap_defines.svh"

module timer_deadline_min_heap
  import tdmh_pkg::*;
#(
  parameter int HEAP_DEPTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  output out_word_t      out_word
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_UP_RD    = 9'b000000010,
    S_UP_CMP   = 9'b000000100,
    S_POP_CHK  = 9'b000001000,
    S_POP_LAST = 9'b000010000,
    S_DN_L     = 9'b000100000,
    S_DN_R     = 9'b001000000,
    S_DN_RC    = 9'b010000000,
    S_DN_CMP   = 9'b100000000
  } state_t;

  function automatic logic [OCC_BITS-1:0] occ_of(input logic [CW-1:0] c);
    logic [CW+OCC_BITS-1:0] e;
    e = {{OCC_BITS{1'b0}}, c};
    return e[OCC_BITS-1:0];
  endfunction

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic [AW-1:0]          pick_idx_r, pick_idx_nxt;
  entry_t                 moving_r, moving_nxt;
  entry_t                 pick_r, pick_nxt;
  logic [TIME_BITS-1:0]   now_r, now_nxt;
  out_word_t              res_r, res_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [ENTRY_BITS-1:0]  ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [ENTRY_BITS-1:0]  ram_rdata;
  entry_t                 rd_entry;

  logic [AW-1:0]          parent;
  logic [AW+1:0]          left_x;
  logic [AW+1:0]          right_x;
  logic [AW+1:0]          cnt_x;
  logic [CW-1:0]          cnt_dec;
  logic                   emit;

  tdmh_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(HEAP_DEPTH)
  ) u_heap_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_entry = ram_rdata;
  assign parent   = (pos_r - AW'(1)) >> 1;
  assign left_x   = {1'b0, pos_r, 1'b1};
  assign right_x  = left_x + (AW+2)'(1);
  assign cnt_x    = (AW+2)'(count_r);
  assign cnt_dec  = count_r - CW'(1);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    pick_idx_nxt = pick_idx_r;
    moving_nxt   = moving_r;
    pick_nxt     = pick_r;
    now_nxt      = now_r;
    res_nxt      = res_r;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = moving_r;
    ram_raddr    = '0;
    emit         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_word.op == OP_INSERT) begin
            if (in_word.now_time >= in_word.deadline) begin
              emit                 = 1'b1;
              res_nxt.status       = ST_EXPIRED;
              res_nxt.out_tag      = in_word.tag;
              res_nxt.out_deadline = in_word.deadline;
            end else if (count_r == DEPTH_C) begin
              emit                 = 1'b1;
              res_nxt.status       = ST_FULL;
              res_nxt.out_tag      = in_word.tag;
              res_nxt.out_deadline = in_word.deadline;
            end else begin
              pos_nxt             = count_r[AW-1:0];
              count_nxt           = count_r + CW'(1);
              moving_nxt.deadline = in_word.deadline;
              moving_nxt.tag      = in_word.tag;
              state_nxt           = S_UP_RD;
            end
          end else begin
            now_nxt = in_word.now_time;
            if (count_r == '0) begin
              emit                 = 1'b1;
              res_nxt.status       = ST_IDLE;
              res_nxt.out_tag      = '0;
              res_nxt.out_deadline = '0;
            end else begin
              ram_raddr = '0;
              state_nxt = S_POP_CHK;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          ram_we               = 1'b1;
          emit                 = 1'b1;
          res_nxt.status       = ST_INSERTED;
          res_nxt.out_tag      = '0;
          res_nxt.out_deadline = '0;
          state_nxt            = S_IDLE;
        end else begin
          ram_raddr = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (rd_entry.deadline < moving_r.deadline) begin
          emit                 = 1'b1;
          res_nxt.status       = ST_INSERTED;
          res_nxt.out_tag      = '0;
          res_nxt.out_deadline = '0;
          state_nxt            = S_IDLE;
        end else begin
          ram_wdata = rd_entry;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end
      end
      S_POP_CHK: begin
        if (rd_entry.deadline > now_r) begin
          emit                 = 1'b1;
          res_nxt.status       = ST_IDLE;
          res_nxt.out_tag      = '0;
          res_nxt.out_deadline = '0;
          state_nxt            = S_IDLE;
        end else begin
          res_nxt.status       = ST_FIRED;
          res_nxt.out_tag      = rd_entry.tag;
          res_nxt.out_deadline = rd_entry.deadline;
          count_nxt            = cnt_dec;
          ram_raddr            = cnt_dec[AW-1:0];
          pos_nxt              = '0;
          state_nxt            = S_POP_LAST;
        end
      end
      S_POP_LAST: begin
        moving_nxt = rd_entry;
        state_nxt  = S_DN_L;
      end
      S_DN_L: begin
        if (left_x >= cnt_x) begin
          ram_we    = 1'b1;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = left_x[AW-1:0];
          state_nxt = S_DN_R;
        end
      end
      S_DN_R: begin
        pick_nxt     = rd_entry;
        pick_idx_nxt = left_x[AW-1:0];
        if (right_x < cnt_x) begin
          ram_raddr = right_x[AW-1:0];
          state_nxt = S_DN_RC;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_RC: begin
        if (rd_entry.deadline < pick_r.deadline) begin
          pick_nxt     = rd_entry;
          pick_idx_nxt = right_x[AW-1:0];
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (moving_r.deadline < pick_r.deadline) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_wdata = pick_r;
          pos_nxt   = pick_idx_r;
          state_nxt = S_DN_L;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      res_nxt.occupancy = occ_of(count_nxt);
    end
    out_valid_nxt = emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    pick_idx_r <= pick_idx_nxt;
    moving_r   <= moving_nxt;
    pick_r     <= pick_nxt;
    now_r      <= now_nxt;
    res_r      <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = res_r;

  `TDMH_NEVER(a_count_range, clk, rst_n, count_r > DEPTH_C)
  `TDMH_ASSERT(a_start_progress, clk, rst_n, start && !busy |=> out_valid || busy)
  `TDMH_NEVER(a_no_write_idle, clk, rst_n, ram_we && state_r == S_IDLE)

endmodule

`default_nettype wire

/* dv/timer_deadline_min_heap_tb.sv */
`timescale 1ns / 1ps

module timer_deadline_min_heap_tb;
  import tdmh_pkg::*;

  localparam int DEPTH = 32;
  localparam logic [TIME_BITS-1:0] T_MAX = '1;
  localparam logic [TAG_BITS-1:0] TAG_MAX = '1;
  localparam int ITEM_TARGET = 1600;

  typedef enum {EP_FILL, EP_DRAIN, EP_MIXED} episode_t;

  typedef struct {
    in_word_t  stim;
    bit        fixed;
    out_word_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  entry_t    slots [DEPTH];
  int        held;
  out_word_t awaited [$];
  out_word_t head_word;
  int        errors;

  dir_row_t  dir_rows [$];
  dir_row_t  cur_row;
  out_word_t guess;
  in_word_t  w;
  episode_t  kind;
  int        items;
  int        ep_len;
  int        ins_pct;
  int        spread;
  int        gap;
  bit        no_idle;
  logic [TIME_BITS-1:0] base;

  timer_deadline_min_heap #(.HEAP_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic out_word_t heap_outcome(input in_word_t wd);
    out_word_t r;
    entry_t    tmp;
    int        pos;
    int        parent;
    int        kid;
    r = '0;
    if (wd.op == OP_INSERT) begin
      if (wd.now_time >= wd.deadline) begin
        r.status = ST_EXPIRED;
        r.out_tag = wd.tag;
        r.out_deadline = wd.deadline;
      end else if (held >= DEPTH) begin
        r.status = ST_FULL;
        r.out_tag = wd.tag;
        r.out_deadline = wd.deadline;
      end else begin
        slots[held].deadline = wd.deadline;
        slots[held].tag = wd.tag;
        pos = held;
        held++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (slots[parent].deadline < slots[pos].deadline) break;
          tmp = slots[parent];
          slots[parent] = slots[pos];
          slots[pos] = tmp;
          pos = parent;
        end
        r.status = ST_INSERTED;
      end
    end else if (held == 0 || slots[0].deadline > wd.now_time) begin
      r.status = ST_IDLE;
    end else begin
      r.status = ST_FIRED;
      r.out_tag = slots[0].tag;
      r.out_deadline = slots[0].deadline;
      held--;
      slots[0] = slots[held];
      pos = 0;
      while (2 * pos + 1 < held) begin
        kid = 2 * pos + 1;
        if (kid + 1 < held && slots[kid + 1].deadline < slots[kid].deadline) kid++;
        if (slots[pos].deadline < slots[kid].deadline) break;
        tmp = slots[pos];
        slots[pos] = slots[kid];
        slots[kid] = tmp;
        pos = kid;
      end
    end
    r.occupancy = held[OCC_BITS-1:0];
    return r;
  endfunction

  function automatic dir_row_t row(input logic op, input logic [TIME_BITS-1:0] now,
                                   input logic [TIME_BITS-1:0] dl,
                                   input logic [TAG_BITS-1:0] tg, input bit fixed,
                                   input logic [STATUS_BITS-1:0] st,
                                   input logic [TAG_BITS-1:0] otg,
                                   input logic [TIME_BITS-1:0] odl,
                                   input logic [OCC_BITS-1:0] occ);
    dir_row_t d;
    d.stim.op = op;
    d.stim.now_time = now;
    d.stim.deadline = dl;
    d.stim.tag = tg;
    d.fixed = fixed;
    d.want.status = st;
    d.want.out_tag = otg;
    d.want.out_deadline = odl;
    d.want.occupancy = occ;
    return d;
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    logic [31:0] lo;
    logic [31:0] hi;
    lo = $urandom;
    hi = $urandom;
    return {hi[15:0], lo};
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_word(input in_word_t wd);
    start <= 1'b1;
    in_word <= wd;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic rest(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_wait();
    rest(1);
    while (awaited.size() != 0) @(posedge clk);
  endtask

  function automatic in_word_t make_word(input int ins_share, input episode_t ek);
    in_word_t wd;
    int       r;
    wd.tag = TAG_BITS'($urandom);
    wd.deadline = rand_time();
    wd.now_time = base;
    r = $urandom_range(0, 19);
    if ($urandom_range(0, 99) < ins_share) begin
      wd.op = OP_INSERT;
      case (r)
        0: wd.deadline = base;
        1: wd.deadline = base - $urandom_range(1, 5000);
        2: wd.deadline = rand_time();
        3: wd.deadline = T_MAX;
        4: wd.now_time = '0;
        default: wd.deadline = base + $urandom_range(1, spread);
      endcase
      if (r == 4) wd.deadline = base + $urandom_range(1, spread);
    end else begin
      wd.op = OP_POLL;
      if (r == 0 || (ek == EP_DRAIN && r == 1)) wd.now_time = T_MAX;
      else if (r == 2) wd.now_time = '0;
      else if (r == 3) wd.now_time = base - 1;
      else wd.now_time = base + $urandom_range(0, spread);
    end
    return wd;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited.size() == 0) begin
        $error("unexpected result word: status %0d tag %h", out_word.status, out_word.out_tag);
        errors++;
      end else begin
        head_word = awaited.pop_front();
        if (out_word.status !== head_word.status) begin
          $error("status: expected %0d, actual %0d", head_word.status, out_word.status);
          errors++;
        end
        if (out_word.out_tag !== head_word.out_tag) begin
          $error("out_tag: expected %h, actual %h", head_word.out_tag, out_word.out_tag);
          errors++;
        end
        if (out_word.out_deadline !== head_word.out_deadline) begin
          $error("out_deadline: expected %h, actual %h", head_word.out_deadline,
                 out_word.out_deadline);
          errors++;
        end
        if (out_word.occupancy !== head_word.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", head_word.occupancy,
                 out_word.occupancy);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    held = 0;
    errors = 0;
    items = 0;
    base = '0;
    spread = 100;

    dir_rows.push_back(row(OP_POLL, '0, '0, '0, 1, ST_IDLE, '0, '0, 0));
    dir_rows.push_back(row(OP_POLL, T_MAX, T_MAX, TAG_MAX, 1, ST_IDLE, '0, '0, 0));
    dir_rows.push_back(row(OP_INSERT, T_MAX, T_MAX, TAG_MAX, 1, ST_EXPIRED, TAG_MAX, T_MAX, 0));
    dir_rows.push_back(row(OP_INSERT, '0, '0, '0, 1, ST_EXPIRED, '0, '0, 0));
    dir_rows.push_back(row(OP_INSERT, 48'd1000, 48'd999, 16'h1234, 1,
                           ST_EXPIRED, 16'h1234, 48'd999, 0));
    dir_rows.push_back(row(OP_INSERT, '0, T_MAX, TAG_MAX, 1, ST_INSERTED, '0, '0, 1));
    dir_rows.push_back(row(OP_INSERT, T_MAX - 1, T_MAX, '0, 1, ST_INSERTED, '0, '0, 2));
    dir_rows.push_back(row(OP_POLL, T_MAX - 1, '0, '0, 0, ST_IDLE, '0, '0, 0));
    dir_rows.push_back(row(OP_INSERT, '0, 48'd1, 16'h0001, 1, ST_INSERTED, '0, '0, 3));
    dir_rows.push_back(row(OP_INSERT, '0, 48'd100, 16'hAAAA, 0, ST_IDLE, '0, '0, 0));
    dir_rows.push_back(row(OP_INSERT, '0, 48'd100, 16'h5555, 0, ST_IDLE, '0, '0, 0));
    dir_rows.push_back(row(OP_INSERT, '0, 48'd100, 16'h0F0F, 0, ST_IDLE, '0, '0, 0));
    dir_rows.push_back(row(OP_POLL, '0, '0, '0, 0, ST_IDLE, '0, '0, 0));
    dir_rows.push_back(row(OP_POLL, 48'd1, T_MAX, TAG_MAX, 0, ST_IDLE, '0, '0, 0));
    for (int i = 0; i < 4; i++)
      dir_rows.push_back(row(OP_POLL, 48'd100, '0, '0, 0, ST_IDLE, '0, '0, 0));
    for (int i = 0; i < 3; i++)
      dir_rows.push_back(row(OP_POLL, T_MAX, '0, '0, 0, ST_IDLE, '0, '0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      cur_row = dir_rows[i];
      send_word(cur_row.stim);
      guess = heap_outcome(cur_row.stim);
      awaited.push_back(cur_row.fixed ? cur_row.want : guess);
      items++;
      rest(pick_gap(0));
    end
    drain_wait();

    while (items < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0: begin kind = EP_FILL;  ins_pct = 90; end
        1: begin kind = EP_DRAIN; ins_pct = 10; end
        default: begin kind = EP_MIXED; ins_pct = 55; end
      endcase
      ep_len = $urandom_range(20, 80);
      spread = ($urandom_range(0, 1) == 0) ? $urandom_range(4, 40) : $urandom_range(41, 4000);
      if ($urandom_range(0, 7) == 0) base = TIME_BITS'($urandom_range(0, 1000));
      else base = {16'($urandom_range(0, 16'hFFFE)), 32'($urandom)};
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ep_len; k++) begin
        w = make_word(ins_pct, kind);
        send_word(w);
        awaited.push_back(heap_outcome(w));
        items++;
        if (w.op == OP_POLL && $urandom_range(0, 3) == 0) base = base + $urandom_range(0, spread);
        gap = pick_gap(no_idle);
        rest(gap);
      end
      if ($urandom_range(0, 3) == 0) drain_wait();
    end

    rest(1);
    while (awaited.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/tdmh_pkg.sv
src/tdmh_ram.sv
src/timer_deadline_min_heap.sv
dv/timer_deadline_min_heap_tb.sv
